// ===== src/psdh_pkg.sv =====
// psdh_pkg: shared word types and width constants for the point to segment distance block
// no dependencies
`default_nettype none

package psdh_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int RADIUS_W   = 16;
    localparam int DIST_W     = 25;

    // derived widths
    localparam int DIF_W  = COORD_BITS + 1;          // coordinate differences
    localparam int PRD_W  = 2 * DIF_W;               // one signed product
    localparam int SQ_W   = 2 * COORD_BITS + 1;      // squared lengths, cross magnitude
    localparam int V_W    = 2 * SQ_W;                // squared cross product
    localparam int RR_W   = 2 * RADIUS_W;            // squared radius
    localparam int Q_W    = SQ_W + 2 * FRAC_BITS;    // radicand, quotient bits
    localparam int ROOT_W = (Q_W + 1) / 2;           // root bits
    localparam int RAD_W  = 2 * ROOT_W;              // radicand padded to digit pairs

    typedef struct packed {
        logic signed [COORD_BITS-1:0] seg_ax;
        logic signed [COORD_BITS-1:0] seg_ay;
        logic signed [COORD_BITS-1:0] seg_bx;
        logic signed [COORD_BITS-1:0] seg_by;
        logic signed [COORD_BITS-1:0] ball_x;
        logic signed [COORD_BITS-1:0] ball_y;
        logic        [RADIUS_W-1:0]   ball_radius;
    } in_word_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance_q8;
        logic              hit;
    } out_word_t;

endpackage

`default_nettype wire

// ===== src/point_segment_distance_hit.sv =====
// point_segment_distance_hit: pipelined point to segment distance and hit test
// depends on psdh_pkg
//
// structure: a 6 stage front end, a divider entry register, a 49 stage restoring divider
// and a 25 stage root; each accepted input word gives its result word on m_
// throughput: one word per cycle; the whole pipeline advances together and holds
// when the result register is full and m_ready is low
// reset: synchronous active-low aresetn clears all stage valid bits, data is not reset
`default_nettype none

module point_segment_distance_hit (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire psdh_pkg::in_word_t    s_word,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output psdh_pkg::out_word_t        m_word
);
    import psdh_pkg::*;

    // divider stage: remainder, numerator bits still to shift in, quotient so far
    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [Q_W-1:0]  num;
        logic [Q_W-1:0]  quo;
        logic [SQ_W-1:0] den;
        logic            hit;
    } div_t;

    // square root stage: partial remainder, partial root, radicand pairs left
    typedef struct packed {
        logic [ROOT_W+1:0] rem;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  rad;
        logic              hit;
    } sq_t;

    logic en;

    // the whole pipe moves when the result register is free or being taken
    assign en      = ~m_valid | m_ready;
    assign s_ready = en;

    // stage 1: differences relative to endpoint a, and point relative to b
    logic signed [DIF_W-1:0] dx1_reg, dy1_reg, px1_reg, py1_reg, qx1_reg, qy1_reg;
    logic [RADIUS_W-1:0]     r1_reg;

    // stage 2: products
    logic signed [PRD_W-1:0] pxdx2_reg, pydy2_reg, dxdx2_reg, dydy2_reg;
    logic signed [PRD_W-1:0] dxpy2_reg, dypx2_reg, pxpx2_reg, pypy2_reg, qxqx2_reg, qyqy2_reg;
    logic [RR_W-1:0]         rr2_reg;

    // stage 3: projection, squared length, cross product, endpoint distances
    logic signed [PRD_W:0] t3_reg, cr3_reg;
    logic [SQ_W-1:0]       len3_reg, d13_reg, d23_reg;
    logic [RR_W-1:0]       rr3_reg;
    logic [PRD_W:0]        len_sum, d1_sum, d2_sum;

    // stage 4: case select, cross magnitude, nearer endpoint
    logic            in4_reg;
    logic [SQ_W-1:0] crm4_reg, dm4_reg, len4_reg;
    logic [RR_W-1:0] rr4_reg;
    logic            in4_next;
    logic [PRD_W:0]  crm_abs;

    // stage 5: squared cross product or endpoint distance, and divisor
    logic [V_W-1:0]  v5_reg;
    logic [SQ_W-1:0] den5_reg;
    logic [RR_W-1:0] rr5_reg;

    // stage 6: radius term for the exact hit compare
    logic [V_W-1:0]       v6_reg;
    logic [SQ_W-1:0]      den6_reg;
    logic [RR_W+SQ_W-1:0] rrd6_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg_vld, v6_reg_vld;

    div_t div_reg [0:Q_W];
    logic dv_reg  [0:Q_W];
    sq_t  sq_reg  [1:ROOT_W];
    logic qv_reg  [1:ROOT_W];
    div_t div0_next;
    sq_t  sq0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            v4_reg     <= 1'b0;
            v5_reg_vld <= 1'b0;
            v6_reg_vld <= 1'b0;
            dv_reg[0]  <= 1'b0;
        end else if (en) begin
            v1_reg     <= s_valid;
            v2_reg     <= v1_reg;
            v3_reg     <= v2_reg;
            v4_reg     <= v3_reg;
            v5_reg_vld <= v4_reg;
            v6_reg_vld <= v5_reg_vld;
            dv_reg[0]  <= v6_reg_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx1_reg <= DIF_W'(s_word.seg_bx) - DIF_W'(s_word.seg_ax);
            dy1_reg <= DIF_W'(s_word.seg_by) - DIF_W'(s_word.seg_ay);
            px1_reg <= DIF_W'(s_word.ball_x) - DIF_W'(s_word.seg_ax);
            py1_reg <= DIF_W'(s_word.ball_y) - DIF_W'(s_word.seg_ay);
            qx1_reg <= DIF_W'(s_word.ball_x) - DIF_W'(s_word.seg_bx);
            qy1_reg <= DIF_W'(s_word.ball_y) - DIF_W'(s_word.seg_by);
            r1_reg  <= s_word.ball_radius;

            pxdx2_reg <= px1_reg * dx1_reg;
            pydy2_reg <= py1_reg * dy1_reg;
            dxdx2_reg <= dx1_reg * dx1_reg;
            dydy2_reg <= dy1_reg * dy1_reg;
            dxpy2_reg <= dx1_reg * py1_reg;
            dypx2_reg <= dy1_reg * px1_reg;
            pxpx2_reg <= px1_reg * px1_reg;
            pypy2_reg <= py1_reg * py1_reg;
            qxqx2_reg <= qx1_reg * qx1_reg;
            qyqy2_reg <= qy1_reg * qy1_reg;
            rr2_reg   <= RR_W'(r1_reg) * RR_W'(r1_reg);

            t3_reg   <= (PRD_W+1)'(pxdx2_reg) + (PRD_W+1)'(pydy2_reg);
            cr3_reg  <= (PRD_W+1)'(dxpy2_reg) - (PRD_W+1)'(dypx2_reg);
            len3_reg <= len_sum[SQ_W-1:0];
            d13_reg  <= d1_sum[SQ_W-1:0];
            d23_reg  <= d2_sum[SQ_W-1:0];
            rr3_reg  <= rr2_reg;

            in4_reg  <= in4_next;
            crm4_reg <= crm_abs[SQ_W-1:0];
            dm4_reg  <= (d13_reg < d23_reg) ? d13_reg : d23_reg;
            len4_reg <= len3_reg;
            rr4_reg  <= rr3_reg;

            // interior: squared cross over length; else nearer endpoint over one
            v5_reg   <= in4_reg ? V_W'(crm4_reg) * V_W'(crm4_reg) : V_W'(dm4_reg);
            den5_reg <= in4_reg ? len4_reg : SQ_W'(1);
            rr5_reg  <= rr4_reg;

            v6_reg   <= v5_reg;
            den6_reg <= den5_reg;
            rrd6_reg <= (RR_W+SQ_W)'(rr5_reg) * (RR_W+SQ_W)'(den5_reg);

            div_reg[0] <= div0_next;
        end
    end

    always_comb begin
        len_sum  = (PRD_W+1)'(dxdx2_reg) + (PRD_W+1)'(dydy2_reg);
        d1_sum   = (PRD_W+1)'(pxpx2_reg) + (PRD_W+1)'(pypy2_reg);
        d2_sum   = (PRD_W+1)'(qxqx2_reg) + (PRD_W+1)'(qyqy2_reg);
        // foot strictly inside the span: projection positive and below the length
        in4_next = !t3_reg[PRD_W] && (t3_reg != '0) &&
                   (t3_reg < $signed((PRD_W+1)'(len3_reg)));
        crm_abs  = cr3_reg[PRD_W] ? (PRD_W+1)'(1'b0) - cr3_reg : cr3_reg;
    end

    // divider entry: high part of the scaled numerator is already below the divisor
    always_comb begin
        div0_next.rem = SQ_W'(v6_reg >> SQ_W);
        div0_next.num = Q_W'(v6_reg[SQ_W-1:0]) << (2 * FRAC_BITS);
        div0_next.quo = '0;
        div0_next.den = den6_reg;
        div0_next.hit = (V_W+RR_W)'(v6_reg) <= (V_W+RR_W)'(rrd6_reg);
    end

    // restoring divider, one quotient bit per stage
    for (genvar k = 0; k < Q_W; k++) begin : g_div
        logic [SQ_W:0] sh;
        logic          qbit;
        div_t          nx;

        always_comb begin
            sh      = {div_reg[k].rem, div_reg[k].num[Q_W-1]};
            qbit    = sh >= (SQ_W+1)'(div_reg[k].den);
            nx      = div_reg[k];
            nx.rem  = qbit ? SQ_W'(sh - (SQ_W+1)'(div_reg[k].den)) : SQ_W'(sh);
            nx.num  = div_reg[k].num << 1;
            nx.quo  = {div_reg[k].quo[Q_W-2:0], qbit};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[k+1] <= 1'b0;
            end else if (en) begin
                dv_reg[k+1] <= dv_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                div_reg[k+1] <= nx;
            end
        end
    end

    always_comb begin
        sq0.rem  = '0;
        sq0.root = '0;
        sq0.rad  = RAD_W'(div_reg[Q_W].quo);
        sq0.hit  = div_reg[Q_W].hit;
    end

    // digit by digit square root, one root bit per stage
    for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
        sq_t           cur;
        logic          cv;
        logic [ROOT_W+3:0] sh;
        logic [ROOT_W+3:0] trial;
        logic          rbit;
        sq_t           nx;

        if (j == 0) begin : g_first
            assign cur = sq0;
            assign cv  = dv_reg[Q_W];
        end else begin : g_rest
            assign cur = sq_reg[j];
            assign cv  = qv_reg[j];
        end

        always_comb begin
            sh      = {cur.rem, cur.rad[RAD_W-1:RAD_W-2]};
            trial   = (ROOT_W+4)'({cur.root, 2'b01});
            rbit    = sh >= trial;
            nx      = cur;
            nx.rem  = rbit ? (ROOT_W+2)'(sh - trial) : (ROOT_W+2)'(sh);
            nx.root = {cur.root[ROOT_W-2:0], rbit};
            nx.rad  = cur.rad << 2;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                qv_reg[j+1] <= 1'b0;
            end else if (en) begin
                qv_reg[j+1] <= cv;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_reg[j+1] <= nx;
            end
        end
    end

    // last root stage doubles as the result register
    assign m_valid            = qv_reg[ROOT_W];
    assign m_word.distance_q8 = DIST_W'(sq_reg[ROOT_W].root);
    assign m_word.hit         = sq_reg[ROOT_W].hit;

endmodule

`default_nettype wire

// ===== src/psdh_check.sv =====
// psdh_check: port-level checks for point_segment_distance_hit, bound to the top level
// depends on psdh_pkg
`default_nettype none

module psdh_check (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire psdh_pkg::in_word_t  s_word,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire psdh_pkg::out_word_t m_word
);
    import psdh_pkg::*;

    // an offered input word stays put until taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_word))
        else $error("input word changed while waiting");

    // a held result word stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word))
        else $error("result word changed while stalled");

    // input side stalls only when the result word is stuck
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready does not follow output stall");

    // nothing comes out right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // distance stays within the reachable range
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_word.distance_q8 <= DIST_W'(23726592))
        else $error("distance out of range");

endmodule

bind point_segment_distance_hit psdh_check u_psdh_check (.*);

`default_nettype wire

// ===== test/tb_point_segment_distance_hit.sv =====
// tb_point_segment_distance_hit: self-checking testbench for the point to segment distance block
// depends on psdh_pkg and point_segment_distance_hit; randomized words checked against an
// internal exact-integer predictor
`default_nettype none

module tb_point_segment_distance_hit;
    import psdh_pkg::*;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_word = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_word;

    // expected result words, oldest first
    out_word_t expected_results[$];
    int        error_count = 0;
    bit        idle_enable = 1'b1;
    bit        hold_sink = 1'b0;

    point_segment_distance_hit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_word(s_word),
        .m_valid(m_valid), .m_ready(m_ready), .m_word(m_word)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // largest n with n*n*den <= lim, exact in 160-bit math
    function automatic logic [63:0] isqrt_bound(logic [159:0] lim, logic [63:0] den);
        logic [63:0]  n;
        logic [63:0]  c;
        logic [159:0] s;
        n = 0;
        for (int b = COORD_BITS + FRAC_BITS + 2; b >= 0; b--) begin
            c = n | (64'd1 << b);
            s = 160'(c) * 160'(c) * 160'(den);
            if (s <= lim) n = c;
        end
        return n;
    endfunction

    // distance and hit for one segment query
    function automatic out_word_t segment_distance(in_word_t w);
        longint ax, ay, px, py, dx, dy, t, len2, cr, qx, qy, d1, d2, dm;
        logic [159:0] c2, lim, rr;
        logic [63:0]  dist_q, r;
        bit           hit;
        out_word_t    o;
        ax = w.seg_ax;  ay = w.seg_ay;
        px = longint'(w.ball_x) - ax;
        py = longint'(w.ball_y) - ay;
        dx = longint'(w.seg_bx) - ax;
        dy = longint'(w.seg_by) - ay;
        r  = w.ball_radius;
        t  = px * dx + py * dy;
        len2 = dx * dx + dy * dy;
        if (t > 0 && t < len2) begin
            // foot strictly inside the segment: perpendicular distance
            cr = dx * py - dy * px;
            if (cr < 0) cr = -cr;
            c2   = 160'(cr) * 160'(cr);
            lim  = c2 << (2 * FRAC_BITS);
            rr   = 160'(r * r) * 160'(len2);
            dist_q = isqrt_bound(lim, 64'(len2));
            hit  = c2 <= rr;
        end else begin
            // nearer endpoint, covers ties and the degenerate segment
            qx = px - dx;  qy = py - dy;
            d1 = px * px + py * py;
            d2 = qx * qx + qy * qy;
            dm = d1 < d2 ? d1 : d2;
            lim  = 160'(dm) << (2 * FRAC_BITS);
            dist_q = isqrt_bound(lim, 64'd1);
            hit  = 64'(dm) <= r * r;
        end
        if (dist_q > (64'd1 << DIST_W) - 1) dist_q = (64'd1 << DIST_W) - 1;
        o.distance_q8 = dist_q[DIST_W-1:0];
        o.hit = hit;
        return o;
    endfunction

    // offer one word, holding it until accepted; valid drops only for an idle burst
    task automatic send_word(in_word_t w);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_word  <= w;
        s_valid <= 1'b1;
        expected_results = {expected_results, segment_distance(w)};
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic in_word_t make_word(int ax, int ay, int bx, int by,
                                          int x, int y, int rad);
        in_word_t w;
        w.seg_ax = ax[15:0]; w.seg_ay = ay[15:0];
        w.seg_bx = bx[15:0]; w.seg_by = by[15:0];
        w.ball_x = x[15:0];  w.ball_y = y[15:0];
        w.ball_radius = rad[15:0];
        return w;
    endfunction

    function automatic in_word_t random_word();
        in_word_t    w;
        int          span;
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        w = raw[$bits(in_word_t)-1:0];
        // mostly keep geometry local so hits and interior feet are common
        if ($urandom_range(0, 2) != 0) begin
            span = 1 << $urandom_range(2, 12);
            w.seg_bx = w.seg_ax + 16'($urandom_range(0, span) - span / 2);
            w.seg_by = w.seg_ay + 16'($urandom_range(0, span) - span / 2);
            w.ball_x = w.seg_ax + 16'($urandom_range(0, 2 * span) - span);
            w.ball_y = w.seg_ay + 16'($urandom_range(0, 2 * span) - span);
            w.ball_radius = 16'($urandom_range(0, span));
        end
        return w;
    endfunction

    // extremes, degenerate, axis-aligned and endpoint-tie segments
    task automatic test_directed();
        send_word(make_word(0, 0, 0, 0, 0, 0, 0));
        send_word(make_word(5, 5, 5, 5, 8, 9, 5));
        send_word(make_word(0, 0, 10, 0, 5, 3, 3));
        send_word(make_word(0, 0, 10, 0, 5, 3, 2));
        send_word(make_word(0, 0, 0, 10, -4, 5, 4));
        send_word(make_word(0, 0, 10, 0, 0, 7, 7));
        send_word(make_word(0, 0, 10, 0, 10, -7, 6));
        send_word(make_word(0, 0, 10, 0, -3, 4, 5));
        send_word(make_word(0, 0, 10, 0, 13, 4, 4));
        send_word(make_word(-32768, -32768, 32767, 32767, 32767, -32768, 65535));
        send_word(make_word(-32768, -32768, -32768, -32768, 32767, 32767, 65535));
        send_word(make_word(32767, -32768, -32768, 32767, 32767, 32767, 0));
        send_word(make_word(-32768, 0, 32767, 0, 0, -32768, 32768));
        send_word(make_word(-32768, 32767, -32768, -32768, 32767, 0, 65535));
        send_word(make_word(0, 0, 3, 4, 4, -3, 5));
        send_word(make_word(1, 2, 7, 11, 3, 5, 1));
        send_word(make_word(-1, -1, -1, -1, -1, -1, 65535));
    endtask

    task automatic test_random(int n);
        repeat (n) send_word(random_word());
    endtask

    // sink stalls long while the source keeps offering, filling the pipeline
    task automatic test_backpressure();
        hold_sink = 1'b1;
        fork
            test_random(150);
            begin
                repeat (300) @(posedge aclk);
                hold_sink = 1'b0;
            end
        join
    endtask

    // result sink with idle bursts
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (hold_sink) m_ready <= 1'b0;
            else if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 17) - 1;
                m_ready <= 1'b0;
            end else m_ready <= 1'b1;
        end
    end

    // compare each accepted result word with the oldest expectation
    always @(posedge aclk) begin
        out_word_t exp_w;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected word distance=%0d hit=%0b",
                         $time, m_word.distance_q8, m_word.hit);
                error_count++;
            end else begin
                exp_w = expected_results.pop_front();
                if (m_word.distance_q8 !== exp_w.distance_q8) begin
                    $display("%0t: distance_q8 expected %0d actual %0d",
                             $time, exp_w.distance_q8, m_word.distance_q8);
                    error_count++;
                end
                if (m_word.hit !== exp_w.hit) begin
                    $display("%0t: hit expected %0b actual %0b",
                             $time, exp_w.hit, m_word.hit);
                    error_count++;
                end
            end
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(200);
        test_backpressure();
        // last stretch runs at full rate
        idle_enable = 1'b0;
        test_random(150);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (error_count == 0)
            $display("point_segment_distance_hit verification clean");
        else
            $display("point_segment_distance_hit verification failed");
        $finish;
    end

    initial begin
        #3000000;
        $display("point_segment_distance_hit verification failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
src/psdh_pkg.sv
src/point_segment_distance_hit.sv
src/psdh_check.sv
test/tb_point_segment_distance_hit.sv
